/* rtl/core/fli_pkg.sv */
package fli_pkg;

    localparam int FACTOR_W = 7;
    localparam int PHASE_W  = 6;

    localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR = 7'd8;
    localparam logic [FACTOR_W-1:0] MAX_FACTOR     = 7'd64;

    // item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // configuration register indexes
    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_MUTE   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DONE
    } fli_state_t;

    // zero means the default factor, anything above the maximum saturates
    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] raw);
        logic [FACTOR_W-1:0] f;
        begin
            if (raw == '0)
                f = DEFAULT_FACTOR;
            else if (raw > MAX_FACTOR)
                f = MAX_FACTOR;
            else
                f = raw;
            return f;
        end
    endfunction

endpackage

/* rtl/core/fifo_linear_interp_upsampler.sv */
// channel  | handshake                     | payload
// ---------+-------------------------------+------------------------------
// in       | in_valid / in_stall (driven)  | command, sample_in
// out      | out_valid / out_stall         | sample_out
// cfg      | cfg_we (no wait)              | cfg_index, cfg_data
//
// A write item leaves in_stall low. A tick item holds in_stall while it works:
// ring read (fetch, load) when it pops a sample, then multiply, divider start,
// SAMPLE_BITS + 7 divider steps and output load.
// The next item can be taken in the same cycle in which in_stall drops.
// A tick holds in its last state while a finished output still waits under out_stall.
// Write items are taken while a finished output still waits under out_stall.
// Reset clears pointers, samples and phase; ring contents are undefined.
module fifo_linear_interp_upsampler
    import fli_pkg::*;
#(
    parameter int RING_DEPTH  = 8192,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] sample_out,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [FACTOR_W-1:0]    cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int MAG_W = SAMPLE_BITS + 1;
    localparam int PRD_W = MAG_W + PHASE_W;
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

    fli_state_t state_reg, state_next;

    logic [FACTOR_W-1:0]    factor_reg;
    logic                   mute_reg;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic [PTR_W-1:0]       rp_reg, rp_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [PHASE_W-1:0]     ph_reg, ph_next;
    logic [FACTOR_W-1:0]    fac_reg, fac_next;
    logic [PRD_W-1:0]       prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    logic                   in_take;
    logic                   out_take;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       rp_inc;
    logic                   ring_full;
    logic                   ring_empty;
    logic [FACTOR_W-1:0]    fac_now;
    logic [PHASE_W-1:0]     ph_eff;
    logic [FACTOR_W-1:0]    ph_inc;
    logic [MAG_W-1:0]       diff;
    logic [MAG_W-1:0]       mag;
    logic                   div_start;
    logic                   div_done;
    logic [PRD_W-1:0]       quot;
    logic [SUM_W-1:0]       q_signed;
    logic [SUM_W-1:0]       sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;

    assign wp_inc     = (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
    assign rp_inc     = (rp_reg == LAST_PTR) ? '0 : rp_reg + 1'b1;
    assign ring_full  = (wp_inc == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);

    assign fac_now = eff_factor(factor_reg);
    assign ph_eff  = ({1'b0, phase_reg} >= fac_now) ? '0 : phase_reg;
    assign ph_inc  = {1'b0, ph_eff} + 1'b1;

    assign diff = {cur_reg[SAMPLE_BITS-1], cur_reg} - {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;

    // quotient never exceeds the magnitude, so MAG_W bits carry it
    assign q_signed = neg_reg ? (~{1'b0, quot[MAG_W-1:0]} + 1'b1) : {1'b0, quot[MAG_W-1:0]};
    assign sum      = {{2{prev_reg[SAMPLE_BITS-1]}}, prev_reg} + q_signed;

    assign mem_wdata = mute_reg ? '0 : sample_in;

    fli_div #(
        .DVD_W (PRD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (fac_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        ph_next        = ph_reg;
        fac_next       = fac_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (command == CMD_WRITE)
                    begin
                        // drop the item when the ring is full
                        if (!ring_full)
                        begin
                            mem_we  = 1'b1;
                            wp_next = wp_inc;
                        end
                    end
                    else
                    begin
                        ph_next    = ph_eff;
                        fac_next   = fac_now;
                        phase_next = (ph_inc == fac_now) ? '0 : ph_inc[PHASE_W-1:0];
                        if (ph_eff == '0)
                        begin
                            prev_next  = cur_reg;
                            state_next = ring_empty ? ST_MUL : ST_FETCH;
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cur_next   = rd_data_reg;
                rp_next    = rp_inc;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = {{PHASE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, ph_reg};
                neg_next   = diff[MAG_W-1];
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum[SAMPLE_BITS-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            factor_reg    <= DEFAULT_FACTOR;
            mute_reg      <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FACTOR: factor_reg <= cfg_data;
                    REG_MUTE:   mute_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg       <= ph_next;
        fac_reg      <= fac_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wp_reg] <= mem_wdata;
        rd_data_reg <= ring_mem[rp_reg];
    end

endmodule

/* rtl/core/fli_div.sv */
module fli_div
    import fli_pkg::*;
#(
    parameter int DVD_W = 23
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [FACTOR_W-1:0] divisor,
    output logic                done,
    output logic [DVD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [FACTOR_W-1:0] rem_reg,   rem_next;
    logic [DVD_W-1:0]    q_reg,     q_next;
    logic [FACTOR_W-1:0] dsr_reg,   dsr_next;

    logic [FACTOR_W:0]   trial;
    logic [FACTOR_W:0]   diff;
    logic                fits;

    // one restoring step per cycle: quotient bits shift in as dividend bits shift out
    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
            q_next   = {q_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/core/fli_chk.sv */
module fli_chk
    import fli_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   command,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] sample_out
);

    // a stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("output changed while stalled");

    // a write item makes no output
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_WRITE && !out_valid |=> !out_valid)
        else $error("write item produced an output");

    // a tick keeps the input side busy while it works
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_TICK |=> in_stall)
        else $error("input taken during tick work");

    // a new output comes only out of tick work
    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output appeared while idle");

endmodule

bind fifo_linear_interp_upsampler fli_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fli_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
);

/* tb/tb_top.sv */
module tb_top;
    import fli_pkg::*;

    localparam int RING_DEPTH  = 8192;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 240;
    localparam int SETTLE      = 40;
    localparam int LIMIT       = 4000000;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic                   cmd;
        logic                   idx;
        logic [SAMPLE_BITS-1:0] data;
        bit                     known;
        logic [SAMPLE_BITS-1:0] want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic                   out_valid;
    logic                   out_stall;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [FACTOR_W-1:0]    cfg_data;

    fifo_linear_interp_upsampler #(
        .RING_DEPTH (RING_DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample_out(sample_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted upsampler state
    logic signed [SAMPLE_BITS-1:0] ring_copy [RING_DEPTH];
    logic [12:0]                   wr_ptr;
    logic [12:0]                   rd_ptr;
    logic signed [SAMPLE_BITS-1:0] prev_smp;
    logic signed [SAMPLE_BITS-1:0] cur_smp;
    int                            phase_cnt;
    logic [FACTOR_W-1:0]           factor_reg;
    logic                          mute_reg;

    logic [SAMPLE_BITS-1:0] pending_samples [$];
    stim_row_t              directed_rows [$];

    int  mismatches;
    int  results_seen;
    int  writes_taken;
    int  writes_dropped;
    int  ticks_taken;
    int  factor_settings;
    int  cycles = 0;
    int  burst_left;
    bit  calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // apply one accepted item to the predicted state
    task automatic interp_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp,
                               output bit has_out, output logic [SAMPLE_BITS-1:0] smp_out);
        int f;
        int diff;
        int res;
        logic [12:0] nxt;
        begin
            has_out = 1'b0;
            smp_out = '0;
            if (factor_reg == '0)
                f = DEFAULT_FACTOR;
            else if (factor_reg > MAX_FACTOR)
                f = MAX_FACTOR;
            else
                f = factor_reg;
            if (cmd == CMD_WRITE)
            begin
                nxt = wr_ptr + 13'd1;
                if (nxt != rd_ptr)
                begin
                    ring_copy[wr_ptr] = mute_reg ? '0 : smp;
                    wr_ptr = nxt;
                    writes_taken++;
                end
                else
                    writes_dropped++;
            end
            else
            begin
                ticks_taken++;
                if (phase_cnt >= f)
                    phase_cnt = 0;
                if (phase_cnt == 0)
                begin
                    prev_smp = cur_smp;
                    if (rd_ptr != wr_ptr)
                    begin
                        cur_smp = ring_copy[rd_ptr];
                        rd_ptr = rd_ptr + 13'd1;
                    end
                end
                diff = cur_smp - prev_smp;
                res = prev_smp + (diff * phase_cnt) / f;
                smp_out = res[SAMPLE_BITS-1:0];
                has_out = 1'b1;
                phase_cnt = (phase_cnt + 1) % f;
            end
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        begin
            case ($urandom_range(0, 15))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h0000;
                3: v = 16'hFFFF;
                default: v = SAMPLE_BITS'($urandom);
            endcase
            return v;
        end
    endfunction

    // called right after a falling edge; returns right after a falling edge
    task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp,
                             input bit known, input logic [SAMPLE_BITS-1:0] want);
        bit has_out;
        logic [SAMPLE_BITS-1:0] predicted;
        begin
            if (burst_left == 0)
            begin
                if (!calm)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(negedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            in_valid  <= 1'b1;
            command   <= cmd;
            sample_in <= smp;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            interp_item(cmd, smp, has_out, predicted);
            if (has_out)
                pending_samples.push_back(known ? want : predicted);
            burst_left--;
            @(negedge clk);
        end
    endtask

    // drain, let a trailing write settle, then write the register
    task automatic write_reg(input logic idx, input logic [FACTOR_W-1:0] val);
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            while (pending_samples.size() != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            if (idx == REG_FACTOR)
            begin
                factor_reg = val;
                factor_settings++;
            end
            else
                mute_reg = val[0];
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic add_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
        stim_row_t r;
        begin
            r = '{ROW_ITEM, cmd, REG_FACTOR, smp, 1'b0, '0};
            directed_rows.push_back(r);
        end
    endtask

    task automatic add_known(input logic [SAMPLE_BITS-1:0] want);
        stim_row_t r;
        begin
            r = '{ROW_ITEM, CMD_TICK, REG_FACTOR, '0, 1'b1, want};
            directed_rows.push_back(r);
        end
    endtask

    task automatic add_reg(input logic idx, input logic [SAMPLE_BITS-1:0] val);
        stim_row_t r;
        begin
            r = '{ROW_REG, CMD_WRITE, idx, val, 1'b0, '0};
            directed_rows.push_back(r);
        end
    endtask

    // receiver stall pattern: quiet stretches, light and heavy back-pressure
    initial
    begin
        int mode;
        int span;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 4) != 0);
                    default: out_stall <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        logic [SAMPLE_BITS-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                $display("%0t: sample_out expected no item actual %0d", $realtime,
                         $signed(sample_out));
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample_out !== want)
                begin
                    mismatches++;
                    $display("%0t: sample_out expected %0d actual %0d", $realtime,
                             $signed(want), $signed(sample_out));
                end
            end
        end
    end

    initial
    begin
        int write_pct;
        logic [FACTOR_W-1:0] f;
        logic cmd;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        command   <= CMD_WRITE;
        sample_in <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FACTOR;
        cfg_data  <= '0;
        mismatches = 0;
        results_seen = 0;
        writes_taken = 0;
        writes_dropped = 0;
        ticks_taken = 0;
        factor_settings = 0;
        burst_left = 0;
        calm = 1'b0;
        wr_ptr = '0;
        rd_ptr = '0;
        prev_smp = '0;
        cur_smp = '0;
        phase_cnt = 0;
        factor_reg = DEFAULT_FACTOR;
        mute_reg = 1'b0;

        // empty ring, then extremes at factor one where the output lags one sample
        add_known(16'h0000);
        add_reg(REG_FACTOR, 16'd1);
        add_item(CMD_WRITE, 16'h7FFF);
        add_item(CMD_WRITE, 16'h8000);
        add_item(CMD_WRITE, 16'h0000);
        add_item(CMD_WRITE, 16'h0001);
        add_known(16'h0000);
        add_known(16'h7FFF);
        add_known(16'h8000);
        add_known(16'h0000);
        add_known(16'h0001);
        // largest factor, then lower it below the running phase
        add_reg(REG_FACTOR, 16'd64);
        add_item(CMD_WRITE, 16'h8000);
        add_item(CMD_TICK, 16'h0000);
        add_item(CMD_TICK, 16'hFFFF);
        add_item(CMD_TICK, 16'h0000);
        add_reg(REG_FACTOR, 16'd2);
        add_known(16'h8000);
        // zero falls back to the default, oversize saturates
        add_reg(REG_FACTOR, 16'd0);
        add_item(CMD_WRITE, 16'h7FFF);
        add_item(CMD_TICK, 16'h0000);
        add_item(CMD_TICK, 16'h0000);
        add_reg(REG_FACTOR, 16'd127);
        add_item(CMD_TICK, 16'h0000);
        // muted writes land as zero
        add_reg(REG_MUTE, 16'd1);
        add_item(CMD_WRITE, 16'h1234);
        add_item(CMD_WRITE, 16'hFFFF);
        add_reg(REG_MUTE, 16'd0);
        add_reg(REG_FACTOR, 16'd1);
        add_item(CMD_TICK, 16'h0000);
        add_item(CMD_TICK, 16'h0000);
        add_item(CMD_TICK, 16'h0000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].idx, directed_rows[i].data[FACTOR_W-1:0]);
            else
                send_item(directed_rows[i].cmd, directed_rows[i].data,
                          directed_rows[i].known, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: f = 7'd1;
                1: f = 7'd64;
                2: f = 7'd127;
                3: f = 7'd0;
                4: f = 7'd3;
                default:
                    case ($urandom_range(0, 3))
                        0: f = $urandom_range(1, 8);
                        1: f = $urandom_range(9, 64);
                        2: f = $urandom_range(65, 127);
                        default: f = 7'd0;
                    endcase
            endcase
            write_reg(REG_FACTOR, f);
            write_reg(REG_MUTE, (p == 2) ? 7'd1 : 7'($urandom_range(0, 4) == 0));
            calm = ($urandom_range(0, 3) == 0);
            write_pct = $urandom_range(15, 60);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_TICK;
                send_item(cmd, pick_sample(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("tb_top: %0d writes taken, %0d dropped on a full ring, %0d ticks",
                 writes_taken, writes_dropped, ticks_taken);
        $display("tb_top: %0d output samples checked over %0d factor settings",
                 results_seen, factor_settings);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fli_pkg.sv
rtl/core/fli_div.sv
rtl/core/fifo_linear_interp_upsampler.sv
rtl/core/fli_chk.sv
tb/tb_top.sv
